// File: hw/rtl/bfgp_pkg.sv
// Shared constants, types and helper functions of the box footpoint ground projector.
package bfgp_pkg;

   localparam int POS_FRAC_BITS = 16;
   localparam int PIXEL_BITS    = 11;

   localparam int COEF_W      = 32;
   localparam int COEF_COUNT  = 9;
   localparam int EPS_W       = 16;
   localparam int LIM_W       = 32;
   localparam int LIM_FRAC_BITS = 16;
   localparam int LIM_SHIFT   = 2 * POS_FRAC_BITS - LIM_FRAC_BITS;
   localparam int CLASS_W     = 8;
   localparam int OUT_W       = 24;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;

   // Footpoint in half-pixel units and the projective sums.
   localparam int FOOT_W = PIXEL_BITS + 2;
   localparam int PROD_W = COEF_W + FOOT_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int MAG_W  = SUM_W;

   // Quotient: integer part below 2^CLAMP_BITS, one guard bit for rounding.
   localparam int CLAMP_BITS = 9;
   localparam int QUO_W      = CLAMP_BITS + POS_FRAC_BITS + 1;
   localparam int RND_W      = QUO_W;
   localparam int POS_W      = RND_W + 1;
   localparam int SQ_W       = 2 * RND_W;
   localparam int DIST_W     = SQ_W + 1;
   localparam int CMP_W      = (DIST_W > LIM_W + LIM_SHIFT) ? DIST_W : LIM_W + LIM_SHIFT;
   localparam int DIV_STAGES = QUO_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [RND_W-1:0] CLAMP_MAG = RND_W'(1) << (POS_FRAC_BITS + CLAMP_BITS);

   localparam logic [EPS_W-1:0] EPS_RESET  = EPS_W'(66);
   localparam logic [LIM_W-1:0] NEAR_RESET = LIM_W'(16384);
   localparam logic [LIM_W-1:0] FAR_RESET  = LIM_W'(42598400);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_H0_H1    = 3'd0,
      CSR_COEF_H2_H3    = 3'd1,
      CSR_COEF_H4_H5    = 3'd2,
      CSR_COEF_H6_H7    = 3'd3,
      CSR_COEF_H8       = 3'd4,
      CSR_HORIZON_EPS   = 3'd5,
      CSR_NEAR_LIMIT_SQ = 3'd6,
      CSR_FAR_LIMIT_SQ  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [COEF_COUNT-1:0][COEF_W-1:0] coef;
      logic [EPS_W-1:0]                  eps;
   } proj_cfg_type;

   typedef struct packed {
      logic [LIM_W-1:0] near_sq;
      logic [LIM_W-1:0] far_sq;
   } range_cfg_type;

   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic               reject;
      logic               clamp_x;
      logic               clamp_y;
      logic [CLASS_W-1:0] class_id;
   } div_side_type;

   typedef struct packed {
      logic [MAG_W-1:0] num_x;
      logic [MAG_W-1:0] num_y;
      logic [MAG_W-1:0] den;
      div_side_type     side;
   } queue_entry_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] pend;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] n;
      n = -v;
      return v[SUM_W-1] ? MAG_W'(n) : MAG_W'(v);
   endfunction

   // One restoring division step: bring in the next numerator bit.
   function automatic div_lane_type div_step(input div_lane_type a,
                                             input logic [MAG_W-1:0] den);
      div_lane_type    r;
      logic [MAG_W:0]  t;
      logic [MAG_W:0]  d;
      logic            bit_q;
      t = {a.rem, a.pend[QUO_W-1]};
      d = {1'b0, den};
      bit_q = (t >= d);
      r.rem  = bit_q ? MAG_W'(t - d) : t[MAG_W-1:0];
      r.pend = {a.pend[QUO_W-2:0], 1'b0};
      r.quo  = {a.quo[QUO_W-2:0], bit_q};
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [POS_W:0] v);
      logic signed [63:0] w;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      w  = 64'(v);
      hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (OUT_W - 1));
      if (w > hi) begin
         w = hi;
      end else if (w < lo) begin
         w = lo;
      end
      return w[OUT_W-1:0];
   endfunction

endpackage

// File: hw/rtl/bfgp_front.sv
// Front end: footpoint, homography products and sums, horizon classification.
module bfgp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  bfgp_pkg::proj_cfg_type             cfg,
   input  logic                               in_valid,
   output logic                               in_stall,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]    box_left,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]    box_top,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]    box_wide,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]    box_tall,
   input  logic [bfgp_pkg::CLASS_W-1:0]       class_in,
   output logic                               out_valid,
   input  logic                               out_ready,
   output bfgp_pkg::queue_entry_type          out_entry
);

   logic en;

   logic                              vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic [bfgp_pkg::FOOT_W-1:0]       u2_ff, v2_ff, u2_in, v2_in;
   logic [bfgp_pkg::PIXEL_BITS:0]     tv_sum;
   logic [bfgp_pkg::CLASS_W-1:0]      cls1_ff, cls2_ff, cls3_ff;

   logic signed [bfgp_pkg::PROD_W-1:0] pxu_ff, pxv_ff, pyu_ff, pyv_ff, pwu_ff, pwv_ff;
   logic signed [bfgp_pkg::PROD_W-1:0] pxu_in, pxv_in, pyu_in, pyv_in, pwu_in, pwv_in;
   logic signed [bfgp_pkg::FOOT_W:0]   u2s, v2s;

   logic signed [bfgp_pkg::SUM_W-1:0] nx_ff, ny_ff, w2_ff, nx_in, ny_in, w2_in;

   bfgp_pkg::queue_entry_type         ent_ff, ent_in;
   logic [bfgp_pkg::MAG_W-1:0]        ad;

   assign en       = !(vld4_ff && !out_ready);
   assign in_stall = !en;

   always_comb begin
      tv_sum = (bfgp_pkg::PIXEL_BITS+1)'(box_top) + (bfgp_pkg::PIXEL_BITS+1)'(box_tall);
      u2_in  = bfgp_pkg::FOOT_W'({box_left, 1'b0}) + bfgp_pkg::FOOT_W'(box_wide);
      v2_in  = {tv_sum, 1'b0};
   end

   always_comb begin
      u2s    = $signed({1'b0, u2_ff});
      v2s    = $signed({1'b0, v2_ff});
      pxu_in = $signed(cfg.coef[0]) * u2s;
      pxv_in = $signed(cfg.coef[1]) * v2s;
      pyu_in = $signed(cfg.coef[3]) * u2s;
      pyv_in = $signed(cfg.coef[4]) * v2s;
      pwu_in = $signed(cfg.coef[6]) * u2s;
      pwv_in = $signed(cfg.coef[7]) * v2s;
   end

   always_comb begin
      nx_in = bfgp_pkg::SUM_W'(pxu_ff) + bfgp_pkg::SUM_W'(pxv_ff)
            + (bfgp_pkg::SUM_W'($signed(cfg.coef[2])) <<< 1);
      ny_in = bfgp_pkg::SUM_W'(pyu_ff) + bfgp_pkg::SUM_W'(pyv_ff)
            + (bfgp_pkg::SUM_W'($signed(cfg.coef[5])) <<< 1);
      w2_in = bfgp_pkg::SUM_W'(pwu_ff) + bfgp_pkg::SUM_W'(pwv_ff)
            + (bfgp_pkg::SUM_W'($signed(cfg.coef[8])) <<< 1);
   end

   always_comb begin
      ad                    = bfgp_pkg::mag_of(w2_ff);
      ent_in.num_x          = bfgp_pkg::mag_of(nx_ff);
      ent_in.num_y          = bfgp_pkg::mag_of(ny_ff);
      ent_in.den            = ad;
      ent_in.side.neg_x     = nx_ff[bfgp_pkg::SUM_W-1] ^ w2_ff[bfgp_pkg::SUM_W-1];
      ent_in.side.neg_y     = ny_ff[bfgp_pkg::SUM_W-1] ^ w2_ff[bfgp_pkg::SUM_W-1];
      ent_in.side.reject    = (w2_ff == '0)
                            || (ad < bfgp_pkg::MAG_W'({cfg.eps, 1'b0}));
      ent_in.side.clamp_x   = (ent_in.num_x >> bfgp_pkg::CLAMP_BITS) >= ad;
      ent_in.side.clamp_y   = (ent_in.num_y >> bfgp_pkg::CLAMP_BITS) >= ad;
      ent_in.side.class_id  = cls3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u2_ff   <= u2_in;
         v2_ff   <= v2_in;
         cls1_ff <= class_in;
         pxu_ff  <= pxu_in;
         pxv_ff  <= pxv_in;
         pyu_ff  <= pyu_in;
         pyv_ff  <= pyv_in;
         pwu_ff  <= pwu_in;
         pwv_ff  <= pwv_in;
         cls2_ff <= cls1_ff;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         w2_ff   <= w2_in;
         cls3_ff <= cls2_ff;
         ent_ff  <= ent_in;
      end
   end

   assign out_valid = vld4_ff;
   assign out_entry = ent_ff;

endmodule

// File: hw/rtl/bfgp_queue.sv
// Short queue between the front end and the division back end.
module bfgp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  bfgp_pkg::queue_entry_type  in_entry,
   output logic                       out_valid,
   input  logic                       out_ready,
   output bfgp_pkg::queue_entry_type  out_entry
);

   bfgp_pkg::queue_entry_type        mem_ff [bfgp_pkg::QUEUE_DEPTH];
   logic [bfgp_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [bfgp_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                             push, pop;

   assign in_ready  = (cnt_ff != bfgp_pkg::QCNT_W'(bfgp_pkg::QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bfgp_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + bfgp_pkg::QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + bfgp_pkg::QCNT_W'(push) - bfgp_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

// File: hw/rtl/bfgp_divider.sv
// Pipelined restoring divider, two numerator lanes sharing one denominator.
module bfgp_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [bfgp_pkg::MAG_W-1:0]    num_x,
   input  logic [bfgp_pkg::MAG_W-1:0]    num_y,
   input  logic [bfgp_pkg::MAG_W-1:0]    den,
   input  bfgp_pkg::div_side_type        in_side,
   output logic                          out_valid,
   output logic [bfgp_pkg::QUO_W-1:0]    quo_x,
   output logic [bfgp_pkg::QUO_W-1:0]    quo_y,
   output bfgp_pkg::div_side_type        out_side
);

   localparam int N = bfgp_pkg::DIV_STAGES;

   bfgp_pkg::div_lane_type        lx_ff [N];
   bfgp_pkg::div_lane_type        ly_ff [N];
   bfgp_pkg::div_lane_type        lx_in [N];
   bfgp_pkg::div_lane_type        ly_in [N];
   logic [bfgp_pkg::MAG_W-1:0]    den_ff [N];
   bfgp_pkg::div_side_type        side_ff [N];
   logic [N-1:0]                  vld_ff;
   bfgp_pkg::div_lane_type        ix, iy;

   always_comb begin
      ix.rem  = num_x >> bfgp_pkg::CLAMP_BITS;
      ix.pend = {num_x[bfgp_pkg::CLAMP_BITS-1:0], (bfgp_pkg::POS_FRAC_BITS+1)'(0)};
      ix.quo  = '0;
      iy.rem  = num_y >> bfgp_pkg::CLAMP_BITS;
      iy.pend = {num_y[bfgp_pkg::CLAMP_BITS-1:0], (bfgp_pkg::POS_FRAC_BITS+1)'(0)};
      iy.quo  = '0;
      lx_in[0] = bfgp_pkg::div_step(ix, den);
      ly_in[0] = bfgp_pkg::div_step(iy, den);
      for (int k = 1; k < N; k++) begin
         lx_in[k] = bfgp_pkg::div_step(lx_ff[k-1], den_ff[k-1]);
         ly_in[k] = bfgp_pkg::div_step(ly_ff[k-1], den_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= den;
         side_ff[0] <= in_side;
         for (int k = 0; k < N; k++) begin
            lx_ff[k] <= lx_in[k];
            ly_ff[k] <= ly_in[k];
         end
         for (int k = 1; k < N; k++) begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign quo_x     = lx_ff[N-1].quo;
   assign quo_y     = ly_ff[N-1].quo;
   assign out_side  = side_ff[N-1];

endmodule

// File: hw/rtl/bfgp_back.sv
// Back end: division, rounding, distance check, offset and saturation of the result.
module bfgp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  bfgp_pkg::range_cfg_type        rng,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  bfgp_pkg::queue_entry_type      in_entry,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic [bfgp_pkg::OUT_W-1:0]     ground_fwd,
   output logic [bfgp_pkg::OUT_W-1:0]     ground_left,
   output logic                           horizon_reject,
   output logic                           in_range,
   output logic [bfgp_pkg::CLASS_W-1:0]   class_out
);

   logic                               en;
   logic                               dv_vld;
   logic [bfgp_pkg::QUO_W-1:0]         dq_x, dq_y;
   bfgp_pkg::div_side_type             dv_side;

   logic                               vld1_ff, vld2_ff, out_vld_ff;
   bfgp_pkg::div_side_type             side1_ff, side2_ff;
   logic [bfgp_pkg::RND_W-1:0]         mx_ff, my_ff, mx_in, my_in;
   logic [bfgp_pkg::QUO_W:0]           rx, ry;
   logic [bfgp_pkg::SQ_W-1:0]          sqx_ff, sqy_ff;
   logic signed [bfgp_pkg::POS_W-1:0]  px_ff, py_ff, px_in, py_in;

   logic [bfgp_pkg::CMP_W-1:0]         dist_sq, near_w, far_w;
   logic signed [bfgp_pkg::POS_W:0]    fwd_w, left_w;
   logic [bfgp_pkg::OUT_W-1:0]         fwd_ff, left_ff, fwd_in, left_in;
   logic                               rej_ff, inr_ff, inr_in;
   logic [bfgp_pkg::CLASS_W-1:0]       cls_ff;

   assign en       = !out_vld_ff || !out_stall;
   assign in_ready = en;

   bfgp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_valid),
      .num_x    (in_entry.num_x),
      .num_y    (in_entry.num_y),
      .den      (in_entry.den),
      .in_side  (in_entry.side),
      .out_valid(dv_vld),
      .quo_x    (dq_x),
      .quo_y    (dq_y),
      .out_side (dv_side)
   );

   // Round half away from zero on magnitudes; large quotients pin to the clamp.
   always_comb begin
      rx    = ({1'b0, dq_x} + (bfgp_pkg::QUO_W+1)'(1)) >> 1;
      ry    = ({1'b0, dq_y} + (bfgp_pkg::QUO_W+1)'(1)) >> 1;
      mx_in = dv_side.clamp_x ? bfgp_pkg::CLAMP_MAG : rx[bfgp_pkg::RND_W-1:0];
      my_in = dv_side.clamp_y ? bfgp_pkg::CLAMP_MAG : ry[bfgp_pkg::RND_W-1:0];
   end

   always_comb begin
      px_in = side1_ff.neg_x ? -$signed({1'b0, mx_ff}) : $signed({1'b0, mx_ff});
      py_in = side1_ff.neg_y ? -$signed({1'b0, my_ff}) : $signed({1'b0, my_ff});
   end

   always_comb begin
      dist_sq = bfgp_pkg::CMP_W'(sqx_ff) + bfgp_pkg::CMP_W'(sqy_ff);
      near_w  = bfgp_pkg::CMP_W'(rng.near_sq) << bfgp_pkg::LIM_SHIFT;
      far_w   = bfgp_pkg::CMP_W'(rng.far_sq) << bfgp_pkg::LIM_SHIFT;
      fwd_w   = (bfgp_pkg::POS_W+1)'(px_ff)
              - ((bfgp_pkg::POS_W+1)'(1) <<< (bfgp_pkg::POS_FRAC_BITS - 1));
      left_w  = -(bfgp_pkg::POS_W+1)'(py_ff);
      if (side2_ff.reject) begin
         fwd_in  = '0;
         left_in = '0;
         inr_in  = 1'b0;
      end else begin
         fwd_in  = bfgp_pkg::sat_out(fwd_w);
         left_in = bfgp_pkg::sat_out(left_w);
         inr_in  = (dist_sq >= near_w) && (dist_sq <= far_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld1_ff    <= dv_vld;
         vld2_ff    <= vld1_ff;
         out_vld_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         side1_ff <= dv_side;
         sqx_ff   <= mx_ff * mx_ff;
         sqy_ff   <= my_ff * my_ff;
         px_ff    <= px_in;
         py_ff    <= py_in;
         side2_ff <= side1_ff;
         fwd_ff   <= fwd_in;
         left_ff  <= left_in;
         rej_ff   <= side2_ff.reject;
         inr_ff   <= inr_in;
         cls_ff   <= side2_ff.class_id;
      end
   end

   assign out_valid      = out_vld_ff;
   assign ground_fwd     = fwd_ff;
   assign ground_left    = left_ff;
   assign horizon_reject = rej_ff;
   assign in_range       = inr_ff;
   assign class_out      = cls_ff;

endmodule

// File: hw/rtl/box_footpoint_ground_projector.sv
// Top level of the box footpoint ground projector: registers, front end, queue, back end.
//
//   Channel   Direction   Handshake            Carries
//   req_      in          req_valid/req_stall  one detection box and its class
//   rsp_      out         rsp_valid/rsp_stall  ground position, reject and range flags, class
//   csr_      in          csr_wr_en            write of one configuration register
//
// One transaction is accepted per clock cycle in steady state, while req_stall is low. The
// 26-stage pipelined divider, one quotient bit per stage, makes up most of the pipeline,
// and the front end, the queue and the rounding and saturation stages make up the rest.
// Reset is synchronous and active high; it empties the pipelines and the queue and loads
// the register defaults (zero coefficients, horizon threshold 66, limits 0.25 and 650 m^2).
// A stall on the result side holds the back end only; the front end keeps taking
// transactions until the four-entry queue fills, and only then raises req_stall.
module box_footpoint_ground_projector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]      req_box_left,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]      req_box_top,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]      req_box_wide,
   input  logic [bfgp_pkg::PIXEL_BITS-1:0]      req_box_tall,
   input  logic [bfgp_pkg::CLASS_W-1:0]         req_class_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bfgp_pkg::OUT_W-1:0]    rsp_ground_fwd,
   output logic signed [bfgp_pkg::OUT_W-1:0]    rsp_ground_left,
   output logic                                 rsp_horizon_reject,
   output logic                                 rsp_in_range,
   output logic [bfgp_pkg::CLASS_W-1:0]         rsp_class_out,
   input  logic                                 csr_wr_en,
   input  logic [bfgp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bfgp_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   // Configuration registers. The homography is held as nine signed Q16.16 words;
   // the paired registers carry the even coefficient in their upper half.
   bfgp_pkg::proj_cfg_type      pcfg_ff, pcfg_in;
   bfgp_pkg::range_cfg_type     rcfg_ff, rcfg_in;

   always_comb begin
      pcfg_in = pcfg_ff;
      rcfg_in = rcfg_ff;
      if (csr_wr_en) begin
         case (bfgp_pkg::csr_index_type'(csr_index))
            bfgp_pkg::CSR_COEF_H0_H1: begin
               pcfg_in.coef[0] = csr_wr_data[63:32];
               pcfg_in.coef[1] = csr_wr_data[31:0];
            end
            bfgp_pkg::CSR_COEF_H2_H3: begin
               pcfg_in.coef[2] = csr_wr_data[63:32];
               pcfg_in.coef[3] = csr_wr_data[31:0];
            end
            bfgp_pkg::CSR_COEF_H4_H5: begin
               pcfg_in.coef[4] = csr_wr_data[63:32];
               pcfg_in.coef[5] = csr_wr_data[31:0];
            end
            bfgp_pkg::CSR_COEF_H6_H7: begin
               pcfg_in.coef[6] = csr_wr_data[63:32];
               pcfg_in.coef[7] = csr_wr_data[31:0];
            end
            bfgp_pkg::CSR_COEF_H8: begin
               pcfg_in.coef[8] = csr_wr_data[31:0];
            end
            bfgp_pkg::CSR_HORIZON_EPS: begin
               pcfg_in.eps = csr_wr_data[bfgp_pkg::EPS_W-1:0];
            end
            bfgp_pkg::CSR_NEAR_LIMIT_SQ: begin
               rcfg_in.near_sq = csr_wr_data[bfgp_pkg::LIM_W-1:0];
            end
            bfgp_pkg::CSR_FAR_LIMIT_SQ: begin
               rcfg_in.far_sq = csr_wr_data[bfgp_pkg::LIM_W-1:0];
            end
            default: begin
               pcfg_in = pcfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcfg_ff.coef    <= '0;
         pcfg_ff.eps     <= bfgp_pkg::EPS_RESET;
         rcfg_ff.near_sq <= bfgp_pkg::NEAR_RESET;
         rcfg_ff.far_sq  <= bfgp_pkg::FAR_RESET;
      end else begin
         pcfg_ff <= pcfg_in;
         rcfg_ff <= rcfg_in;
      end
   end

   // Front end to queue, queue to back end.
   logic                        fe_valid, fe_ready;
   bfgp_pkg::queue_entry_type   fe_entry;
   logic                        q_valid, q_ready;
   bfgp_pkg::queue_entry_type   q_entry;
   logic [bfgp_pkg::OUT_W-1:0]  fwd_bits, left_bits;

   bfgp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (pcfg_ff),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .box_left (req_box_left),
      .box_top  (req_box_top),
      .box_wide (req_box_wide),
      .box_tall (req_box_tall),
      .class_in (req_class_in),
      .out_valid(fe_valid),
      .out_ready(fe_ready),
      .out_entry(fe_entry)
   );

   bfgp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fe_valid),
      .in_ready (fe_ready),
      .in_entry (fe_entry),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_entry(q_entry)
   );

   bfgp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .rng           (rcfg_ff),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_entry      (q_entry),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .ground_fwd    (fwd_bits),
      .ground_left   (left_bits),
      .horizon_reject(rsp_horizon_reject),
      .in_range      (rsp_in_range),
      .class_out     (rsp_class_out)
   );

   assign rsp_ground_fwd  = $signed(fwd_bits);
   assign rsp_ground_left = $signed(left_bits);

endmodule
